// ===== hw/rtl/i2c_eeprom_transaction_master_macros.svh =====
// assertion macros for the transaction master rtl
`ifndef I2C_EEPROM_TRANSACTION_MASTER_MACROS_SVH
`define I2C_EEPROM_TRANSACTION_MASTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define I2CEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define I2CEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CEM_ASSERT_NOW(label, ante, cons, msg)
`define I2CEM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/i2cem_pkg.sv =====
package i2cem_pkg;

  // command codes
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_SLOT  = 2'd2;

  // operation codes
  localparam logic [1:0] OP_CUR_READ  = 2'd0;
  localparam logic [1:0] OP_RAND_READ = 2'd1;
  localparam logic [1:0] OP_WRITE     = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  // bus actions
  localparam logic [2:0] ACT_IDLE       = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_DRIVE      = 3'd2;
  localparam logic [2:0] ACT_SAMPLE     = 3'd3;
  localparam logic [2:0] ACT_ACK        = 3'd4;
  localparam logic [2:0] ACT_NACK       = 3'd5;
  localparam logic [2:0] ACT_STOP_READ  = 3'd6;
  localparam logic [2:0] ACT_STOP_WRITE = 3'd7;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_SEL_NACK  = 2'd1;
  localparam logic [1:0] ERR_ADDR_NACK = 2'd2;
  localparam logic [1:0] ERR_DATA_NACK = 2'd3;

  // select byte device type code
  localparam logic [3:0] DEV_TYPE = 4'b1010;

  // bits in a bus byte
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] operation;
    logic [2:0] device;
    logic [7:0] word_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_sample;
  } in_word_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic       bus_bit;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_data;
    logic       done_res;
    logic [1:0] error;
  } out_word_t;

endpackage

// ===== hw/rtl/i2c_eeprom_transaction_master.sv =====
// I2C EEPROM (24C02 style) transaction master, one bus slot per input word.
// Input channel (in_valid / in_stall / in_word): begin, write data or bus slot
// commands. Every accepted word yields exactly one result word on the output
// channel (out_valid / out_stall / out_word) holding the next bus action.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) sets the sampled
// level that counts as acknowledge; it is always ready, and the user must write it
// only while idle; the block itself does not enforce this.
// Throughput: one word per cycle while in_stall is low; the sequencer state
// updates in the cycle of acceptance through a single level of next-state logic.
// The output register is backed by a one-word skid register, so an input word
// is still taken while a result waits on a stalled receiver; in_stall rises
// only once both are full and drops as soon as the receiver takes a word.
// Reset (synchronous, rst_n low) returns the sequencer to idle, empties both
// output registers and sets the acknowledge level to zero.
`include "i2c_eeprom_transaction_master_macros.svh"

module i2c_eeprom_transaction_master (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cem_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cem_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import i2cem_pkg::*;

  // sequencer phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_SEL       = 4'd1;
  localparam logic [3:0] PH_SEL_ACK   = 4'd2;
  localparam logic [3:0] PH_ADDR      = 4'd3;
  localparam logic [3:0] PH_ADDR_ACK  = 4'd4;
  localparam logic [3:0] PH_WAIT_DATA = 4'd5;
  localparam logic [3:0] PH_DATA      = 4'd6;
  localparam logic [3:0] PH_DATA_ACK  = 4'd7;
  localparam logic [3:0] PH_READ      = 4'd8;
  localparam logic [3:0] PH_READ_END  = 4'd9;

  logic       ack_level_r;
  logic [3:0] phase_r, phase_nxt;
  logic [3:0] bit_pos_r, bit_pos_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [1:0] pend_op_r, pend_op_nxt;
  logic [2:0] chip_r, chip_nxt;
  logic [7:0] target_r, target_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;

  out_word_t res;
  out_word_t out_r, out_nxt;
  out_word_t skid_r, skid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;

  logic       in_acc;
  logic       out_take;
  logic       acked;
  logic [3:0] bit_dec;
  logic [7:0] read_shift;
  logic [7:0] bytes_dec;
  logic [1:0] finish_err;
  logic       do_finish;

  // handshakes
  assign in_acc    = in_valid && !skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign cfg_ready = 1'b1;

  // slot helpers
  assign acked      = (in_word.sda_sample == ack_level_r);
  assign bit_dec    = (bit_pos_r != 4'd0) ? (bit_pos_r - 4'd1) : 4'd0;
  assign read_shift = {shift_r[6:0], in_word.sda_sample};
  assign bytes_dec  = bytes_left_r - 8'd1;

  // sequencer next state and result word
  always_comb begin
    phase_nxt      = phase_r;
    bit_pos_nxt    = bit_pos_r;
    shift_nxt      = shift_r;
    pend_op_nxt    = pend_op_r;
    chip_nxt       = chip_r;
    target_nxt     = target_r;
    bytes_left_nxt = bytes_left_r;
    res            = '0;
    do_finish      = 1'b0;
    finish_err     = ERR_OK;

    case (in_word.cmd)
      CMD_BEGIN: begin
        if (phase_r == PH_IDLE && in_word.operation != OP_NONE) begin
          pend_op_nxt    = in_word.operation;
          chip_nxt       = in_word.device;
          target_nxt     = in_word.word_addr;
          bytes_left_nxt = (in_word.byte_count == 8'd0) ? 8'd1 : in_word.byte_count;
          shift_nxt      = {DEV_TYPE, in_word.device, in_word.operation == OP_CUR_READ};
          bit_pos_nxt    = BYTE_BITS;
          phase_nxt      = PH_SEL;
          res.bus_action = ACT_START;
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_WAIT_DATA) begin
          shift_nxt      = in_word.data_byte;
          bit_pos_nxt    = BYTE_BITS - 4'd1;
          phase_nxt      = PH_DATA;
          res.bus_action = ACT_DRIVE;
          res.bus_bit    = in_word.data_byte[7];
        end
      end
      CMD_SLOT: begin
        case (phase_r)
          PH_SEL, PH_ADDR, PH_DATA: begin
            if (bit_pos_r != 4'd0) begin
              bit_pos_nxt    = bit_dec;
              res.bus_action = ACT_DRIVE;
              res.bus_bit    = shift_r[bit_dec[2:0]];
            end else begin
              res.bus_action = ACT_SAMPLE;
              phase_nxt      = phase_r + 4'd1;
            end
          end
          PH_SEL_ACK: begin
            if (!acked) begin
              do_finish  = 1'b1;
              finish_err = ERR_SEL_NACK;
            end else if (pend_op_r == OP_CUR_READ) begin
              shift_nxt      = 8'd0;
              bit_pos_nxt    = BYTE_BITS;
              phase_nxt      = PH_READ;
              res.bus_action = ACT_SAMPLE;
            end else begin
              shift_nxt      = target_r;
              bit_pos_nxt    = BYTE_BITS - 4'd1;
              phase_nxt      = PH_ADDR;
              res.bus_action = ACT_DRIVE;
              res.bus_bit    = target_r[7];
            end
          end
          PH_ADDR_ACK: begin
            if (!acked) begin
              do_finish  = 1'b1;
              finish_err = ERR_ADDR_NACK;
            end else if (pend_op_r == OP_RAND_READ) begin
              pend_op_nxt    = OP_CUR_READ;
              shift_nxt      = {DEV_TYPE, chip_r, 1'b1};
              bit_pos_nxt    = BYTE_BITS;
              phase_nxt      = PH_SEL;
              res.bus_action = ACT_START;
            end else begin
              phase_nxt     = PH_WAIT_DATA;
              res.need_data = 1'b1;
            end
          end
          PH_WAIT_DATA: begin
            res.need_data = 1'b1;
          end
          PH_DATA_ACK: begin
            if (!acked) begin
              do_finish  = 1'b1;
              finish_err = ERR_DATA_NACK;
            end else begin
              bytes_left_nxt = bytes_dec;
              if (bytes_dec != 8'd0) begin
                phase_nxt     = PH_WAIT_DATA;
                res.need_data = 1'b1;
              end else begin
                do_finish = 1'b1;
              end
            end
          end
          PH_READ: begin
            shift_nxt   = read_shift;
            bit_pos_nxt = bit_dec;
            if (bit_dec != 4'd0) begin
              res.bus_action = ACT_SAMPLE;
            end else begin
              res.read_byte  = read_shift;
              res.read_valid = 1'b1;
              bytes_left_nxt = bytes_dec;
              res.bus_action = (bytes_dec != 8'd0) ? ACT_ACK : ACT_NACK;
              phase_nxt      = PH_READ_END;
            end
          end
          PH_READ_END: begin
            if (bytes_left_r != 8'd0) begin
              shift_nxt      = 8'd0;
              bit_pos_nxt    = BYTE_BITS;
              phase_nxt      = PH_READ;
              res.bus_action = ACT_SAMPLE;
            end else begin
              do_finish = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
      default: begin
      end
    endcase

    // stop and close the transaction, with or without error
    if (do_finish) begin
      res.bus_action = (pend_op_r == OP_WRITE) ? ACT_STOP_WRITE : ACT_STOP_READ;
      res.done_res   = 1'b1;
      res.error      = finish_err;
      phase_nxt      = PH_IDLE;
      bit_pos_nxt    = 4'd0;
    end
  end

  // output register with skid stage
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_acc;
      end
    end else if (in_acc) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  // control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_level_r  <= 1'b0;
      phase_r      <= PH_IDLE;
      bit_pos_r    <= 4'd0;
      shift_r      <= 8'd0;
      pend_op_r    <= OP_CUR_READ;
      chip_r       <= 3'd0;
      target_r     <= 8'd0;
      bytes_left_r <= 8'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ack_level_r <= cfg_data;
      end
      if (in_acc) begin
        phase_r      <= phase_nxt;
        bit_pos_r    <= bit_pos_nxt;
        shift_r      <= shift_nxt;
        pend_op_r    <= pend_op_nxt;
        chip_r       <= chip_nxt;
        target_r     <= target_nxt;
        bytes_left_r <= bytes_left_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  // checks
  `I2CEM_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid word without output word")
  `I2CEM_ASSERT_NOW(a_bit_pos_range, 1'b1, bit_pos_r <= BYTE_BITS, "bit position beyond a byte")
  `I2CEM_ASSERT_NEXT(a_done_to_idle, in_acc && res.done_res, phase_r == PH_IDLE, "no idle after stop")
  `I2CEM_ASSERT_NOW(a_read_answer, in_acc && res.read_valid,
    res.bus_action == ACT_ACK || res.bus_action == ACT_NACK, "read byte without ack or nack")

endmodule

// ===== tb/i2cem_action_checker.sv =====
`timescale 1ns / 100ps

module i2cem_action_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  i2cem_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  i2cem_pkg::out_word_t out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  output int                   fail_count,
  output int                   outstanding
);
  import i2cem_pkg::*;

  // sequencer phases of the predicted master
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_SEL, SQ_SEL_ACK, SQ_ADDR, SQ_ADDR_ACK,
    SQ_WAIT, SQ_DATA, SQ_DATA_ACK, SQ_READ, SQ_READ_END
  } seq_t;

  // predicted sequencer state and acknowledge level
  seq_t       seq;
  logic       ack_lvl;
  logic [3:0] bit_cnt;
  logic [7:0] shifter;
  logic [1:0] op_q;
  logic [2:0] chip;
  logic [7:0] addr_q;
  logic [7:0] left_q;

  out_word_t expected_actions[$];
  int        errors = 0;

  // select byte: device type, chip enables, read flag
  function automatic logic [7:0] select_byte(logic rd);
    return {DEV_TYPE, chip, rd};
  endfunction

  // next bit of the shifter onto the bus, msb first
  function automatic out_word_t drive_bit();
    out_word_t r;
    r = '0;
    if (bit_cnt != 0) bit_cnt = bit_cnt - 1'b1;
    r.bus_action = ACT_DRIVE;
    r.bus_bit = shifter[bit_cnt[2:0]];
    return r;
  endfunction

  // stop that ends or aborts a transaction
  function automatic out_word_t stop_word(logic [1:0] err);
    out_word_t r;
    r = '0;
    r.bus_action = (op_q == OP_WRITE) ? ACT_STOP_WRITE : ACT_STOP_READ;
    r.done_res = 1'b1;
    r.error = err;
    seq = SQ_IDLE;
    bit_cnt = '0;
    return r;
  endfunction

  // advance the sequencer by one word and give the bus action it yields
  function automatic out_word_t predict_action(in_word_t w);
    out_word_t r;
    logic      acked;
    r = '0;
    acked = (w.sda_sample == ack_lvl);
    case (w.cmd)
      CMD_BEGIN: begin
        if (seq == SQ_IDLE && w.operation != OP_NONE) begin
          op_q = w.operation;
          chip = w.device;
          addr_q = w.word_addr;
          left_q = (w.byte_count == 8'd0) ? 8'd1 : w.byte_count;
          shifter = select_byte(w.operation == OP_CUR_READ);
          bit_cnt = BYTE_BITS;
          seq = SQ_SEL;
          r.bus_action = ACT_START;
        end
      end
      CMD_DATA: begin
        if (seq == SQ_WAIT) begin
          shifter = w.data_byte;
          bit_cnt = BYTE_BITS;
          seq = SQ_DATA;
          r = drive_bit();
        end
      end
      CMD_SLOT: begin
        case (seq)
          SQ_SEL, SQ_ADDR, SQ_DATA: begin
            if (bit_cnt != 0) begin
              r = drive_bit();
            end else begin
              r.bus_action = ACT_SAMPLE;
              seq = (seq == SQ_SEL) ? SQ_SEL_ACK :
                    (seq == SQ_ADDR) ? SQ_ADDR_ACK : SQ_DATA_ACK;
            end
          end
          SQ_SEL_ACK: begin
            if (!acked) begin
              r = stop_word(ERR_SEL_NACK);
            end else if (op_q == OP_CUR_READ) begin
              shifter = '0;
              bit_cnt = BYTE_BITS;
              seq = SQ_READ;
              r.bus_action = ACT_SAMPLE;
            end else begin
              shifter = addr_q;
              bit_cnt = BYTE_BITS;
              seq = SQ_ADDR;
              r = drive_bit();
            end
          end
          SQ_ADDR_ACK: begin
            if (!acked) begin
              r = stop_word(ERR_ADDR_NACK);
            end else if (op_q == OP_RAND_READ) begin
              // repeated start with a read select
              op_q = OP_CUR_READ;
              shifter = select_byte(1'b1);
              bit_cnt = BYTE_BITS;
              seq = SQ_SEL;
              r.bus_action = ACT_START;
            end else begin
              seq = SQ_WAIT;
              r.need_data = 1'b1;
            end
          end
          SQ_WAIT: r.need_data = 1'b1;
          SQ_DATA_ACK: begin
            if (!acked) begin
              r = stop_word(ERR_DATA_NACK);
            end else begin
              left_q = left_q - 1'b1;
              if (left_q != 0) begin
                seq = SQ_WAIT;
                r.need_data = 1'b1;
              end else begin
                r = stop_word(ERR_OK);
              end
            end
          end
          SQ_READ: begin
            shifter = {shifter[6:0], w.sda_sample};
            if (bit_cnt != 0) bit_cnt = bit_cnt - 1'b1;
            if (bit_cnt != 0) begin
              r.bus_action = ACT_SAMPLE;
            end else begin
              r.read_byte = shifter;
              r.read_valid = 1'b1;
              left_q = left_q - 1'b1;
              r.bus_action = (left_q != 0) ? ACT_ACK : ACT_NACK;
              seq = SQ_READ_END;
            end
          end
          SQ_READ_END: begin
            if (left_q != 0) begin
              shifter = '0;
              bit_cnt = BYTE_BITS;
              seq = SQ_READ;
              r.bus_action = ACT_SAMPLE;
            end else begin
              r = stop_word(ERR_OK);
            end
          end
          default: seq = SQ_IDLE;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch the channels: config, results, then new words
  always @(posedge clk) begin
    out_word_t exp;
    if (!rst_n) begin
      seq = SQ_IDLE;
      ack_lvl = 1'b0;
      bit_cnt = '0;
      shifter = '0;
      op_q = '0;
      chip = '0;
      addr_q = '0;
      left_q = '0;
      expected_actions.delete();
    end else begin
      if (cfg_valid && cfg_ready) ack_lvl = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_actions.size() == 0) begin
          if (errors < 10)
            $display({"%0t: unexpected result word act %0d bit %0d byte %02h ",
                       "rv %0d nd %0d dn %0d err %0d"},
                     $realtime, out_word.bus_action, out_word.bus_bit, out_word.read_byte,
                     out_word.read_valid, out_word.need_data, out_word.done_res,
                     out_word.error);
          errors++;
        end else begin
          exp = expected_actions.pop_front();
          if (out_word !== exp) begin
            if (errors < 10)
              $display({"%0t: mismatch exp act %0d bit %0d byte %02h rv %0d nd %0d dn %0d ",
                        "err %0d / got act %0d bit %0d byte %02h rv %0d nd %0d dn %0d err %0d"},
                       $realtime, exp.bus_action, exp.bus_bit, exp.read_byte,
                       exp.read_valid, exp.need_data, exp.done_res, exp.error,
                       out_word.bus_action, out_word.bus_bit, out_word.read_byte,
                       out_word.read_valid, out_word.need_data, out_word.done_res,
                       out_word.error);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) expected_actions.push_back(predict_action(in_word));
    end
    fail_count <= errors;
    outstanding <= expected_actions.size();
  end

endmodule

// ===== tb/tb_i2c_eeprom_transaction_master.sv =====
`timescale 1ns / 100ps

module tb_i2c_eeprom_transaction_master;
  import i2cem_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_WORDS = 400;
  // command code with no meaning, the block ignores it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int words_sent = 0;
  int nack_pct = 6;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  logic ack_lvl = 1'b0;

  i2c_eeprom_transaction_master u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  i2cem_action_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (stall_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17);
    end
    out_stall <= (stall_left > 0);
  end

  // word with every field random and the given command
  function automatic in_word_t rand_word(logic [1:0] cmd);
    in_word_t w;
    w = $urandom;
    w.cmd = cmd;
    return w;
  endfunction

  // offer one word, with an occasional gap, until it is taken
  task automatic send_word(input in_word_t w);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_slot(input logic sda);
    in_word_t w;
    w = rand_word(CMD_SLOT);
    w.sda_sample = sda;
    send_word(w);
  endtask

  // plain bus slots, with stray words the busy block must ignore
  task automatic send_bits(input int n);
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_word(rand_word(CMD_BEGIN));
          1:       send_word(rand_word(CMD_UNUSED));
          default: send_word(rand_word(CMD_DATA));
        endcase
      end
      send_slot(1'($urandom_range(0, 1)));
    end
  endtask

  // slot carrying the acknowledge level, or now and then the other level
  task automatic ack_slot(output bit ok);
    ok = ($urandom_range(0, 99) >= nack_pct);
    send_slot(ok ? ack_lvl : ~ack_lvl);
  endtask

  // one transaction, cut short where the memory does not acknowledge
  task automatic run_transfer(input logic [1:0] op, input logic [2:0] dev,
                              input logic [7:0] addr, input logic [7:0] cnt);
    in_word_t w;
    bit       ok;
    int       n;
    w = rand_word(CMD_BEGIN);
    w.operation = op;
    w.device = dev;
    w.word_addr = addr;
    w.byte_count = cnt;
    send_word(w);
    send_bits(9);
    ack_slot(ok);
    if (!ok) return;
    if (op != OP_CUR_READ) begin
      send_bits(8);
      ack_slot(ok);
      if (!ok) return;
      if (op == OP_RAND_READ) begin
        send_bits(9);
        ack_slot(ok);
        if (!ok) return;
      end
    end
    n = (cnt == 8'd0) ? 1 : cnt;
    for (int i = 0; i < n; i++) begin
      if (op == OP_WRITE) begin
        // a slot while the block waits for data is answered with need_data
        if ($urandom_range(0, 4) == 0) send_slot(1'($urandom_range(0, 1)));
        send_word(rand_word(CMD_DATA));
        send_bits(8);
        ack_slot(ok);
        if (!ok) return;
      end else begin
        send_bits(9);
      end
    end
  endtask

  // idle-time words that give only an idle action
  task automatic idle_noise();
    in_word_t w;
    case ($urandom_range(0, 3))
      0: send_word(rand_word(CMD_SLOT));
      1: send_word(rand_word(CMD_DATA));
      2: send_word(rand_word(CMD_UNUSED));
      default: begin
        w = rand_word(CMD_BEGIN);
        w.operation = OP_NONE;
        send_word(w);
      end
    endcase
  endtask

  task automatic random_transfer();
    logic [1:0] op;
    logic [7:0] cnt;
    op = 2'($urandom_range(0, 2));
    cnt = 8'($urandom_range(0, 3));
    // long counts only on writes, which a data nack usually ends early
    if ($urandom_range(0, 15) == 0) begin
      op = OP_WRITE;
      cnt = 8'($urandom);
    end
    run_transfer(op, 3'($urandom), 8'($urandom), cnt);
    if ($urandom_range(0, 3) == 0) idle_noise();
  endtask

  // sender holds off until every result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ack_level(input logic lvl);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    ack_lvl = lvl;
  endtask

  // stimulus
  initial begin
    logic levels[4];
    int   target;
    levels = '{1'b1, 1'b0, 1'b1, 1'b0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_ack_level(1'b0);

    // directed: idle words, then select nacks on a long write and a zero-count read
    send_word(rand_word(CMD_SLOT));
    send_word(rand_word(CMD_DATA));
    send_word(rand_word(CMD_UNUSED));
    idle_noise();
    nack_pct = 100;
    run_transfer(OP_WRITE, 3'd7, 8'hFF, 8'hFF);
    run_transfer(OP_CUR_READ, 3'd0, 8'h00, 8'h00);
    nack_pct = 6;

    // random phases, each with its own acknowledge level
    target = words_sent;
    for (int p = 0; p < 4; p++) begin
      drain();
      write_ack_level(levels[p]);
      if (p == 3) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      target = target + PHASE_WORDS;
      while (words_sent < target) random_transfer();
    end

    drain();
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
